[design/nonp_pkg.sv]
// Shared types, widths and codes for the nearest-pose normal orientation block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package nonp_pkg;

  localparam int MAX_POSES = 1024;
  localparam int COORD_W   = 24;
  localparam int NORMAL_W  = 16;
  localparam int IDX_W     = (MAX_POSES > 1) ? $clog2(MAX_POSES) : 1;
  localparam int CNT_W     = $clog2(MAX_POSES + 1);
  localparam int NEAR_W    = 10;
  localparam int STATUS_W  = 3;
  localparam int CMD_W     = 2;

  // A coordinate difference needs one bit more than a coordinate.
  localparam int DIFF_W = COORD_W + 1;
  localparam int MUL_W  = (DIFF_W > NORMAL_W) ? DIFF_W : NORMAL_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam int IN_FIELD_W  = 3 * COORD_W + 3 * NORMAL_W;
  localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 3 * NORMAL_W + 1 + NEAR_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [NORMAL_W-1:0] norm_t;
  typedef logic signed [MUL_W-1:0]    mul_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [CMD_W-1:0]           cmd_t;
  typedef logic [STATUS_W-1:0]        status_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } pose_t;

  // Travels alongside each operand set through the distance unit.
  typedef struct packed {
    logic             dot;
    logic             last;
    logic [IDX_W-1:0] idx;
  } dist_tag_t;

  localparam cmd_t CMD_APPEND = 2'd0;
  localparam cmd_t CMD_ORIENT = 2'd1;
  localparam cmd_t CMD_CLEAR  = 2'd2;

  localparam status_t ST_ORIENTED = 3'd0;
  localparam status_t ST_STORED   = 3'd1;
  localparam status_t ST_DROPPED  = 3'd2;
  localparam status_t ST_NO_POSES = 3'd3;
  localparam status_t ST_CLEARED  = 3'd4;

endpackage

`default_nettype wire

[design/nonp_pose_mem.sv]
// Pose store: one write port, one read port with registered read data.
// Depends on nonp_pkg for the pose type and depth.
`default_nettype none

module nonp_pose_mem
  import nonp_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  pose_t            wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output pose_t            rd_data
);

  pose_t mem [MAX_POSES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/nonp_dist_unit.sv]
// Shared three-lane arithmetic unit: difference, multiply and sum stages.
// Gives a squared distance, or a dot product with the normal. Uses nonp_pkg.
`default_nettype none

module nonp_dist_unit
  import nonp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  input  dist_tag_t in_tag,
  input  pose_t     pose,
  input  pose_t     point,
  input  norm_t     nrm_x,
  input  norm_t     nrm_y,
  input  norm_t     nrm_z,
  output logic      out_vld,
  output dist_tag_t out_tag,
  output sum_t      out_sum
);

  mul_t      diff [3];
  mul_t      nrm  [3];
  mul_t      a_r  [3];
  mul_t      b_r  [3];
  prod_t     prod_r [3];
  logic      s1_vld_r, s2_vld_r, s3_vld_r;
  dist_tag_t s1_tag_r, s2_tag_r, s3_tag_r;
  sum_t      sum_r;

  always_comb begin
    diff[0] = mul_t'(pose.x) - mul_t'(point.x);
    diff[1] = mul_t'(pose.y) - mul_t'(point.y);
    diff[2] = mul_t'(pose.z) - mul_t'(point.z);
    nrm[0]  = mul_t'(nrm_x);
    nrm[1]  = mul_t'(nrm_y);
    nrm[2]  = mul_t'(nrm_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
    s1_tag_r <= in_tag;
    s2_tag_r <= s1_tag_r;
    s3_tag_r <= s2_tag_r;
    for (int k = 0; k < 3; k++) begin
      // In dot mode the first operand is the normal, otherwise the difference itself.
      a_r[k]    <= in_tag.dot ? nrm[k] : diff[k];
      b_r[k]    <= diff[k];
      prod_r[k] <= a_r[k] * b_r[k];
    end
    sum_r <= sum_t'(prod_r[0]) + sum_t'(prod_r[1]) + sum_t'(prod_r[2]);
  end

  assign out_vld = s3_vld_r;
  assign out_tag = s3_tag_r;
  assign out_sum = sum_r;

endmodule

`default_nettype wire

[design/normal_orient_to_nearest_pose.sv]
// Top level: stream ports, command sequencer and result register.
// Instantiates nonp_pose_mem and nonp_dist_unit; uses nonp_pkg.
`default_nettype none

// In an orient transaction the stored poses are read from the store one per
// cycle and streamed through the shared distance unit (memory read, difference,
// multiply, sum), after which the winning pose is read once more and the same
// unit forms the dot product with the normal. The single read port of the pose
// store sets the one-pose-per-cycle pace. Append, clear and orient with an
// empty list go straight to the output state. The block takes no new input
// while a transaction is being worked on; a finished result waits in the
// output register while the next input is accepted. The pose store needs no
// clearing after reset: only entries below the pose count are ever read.
module normal_orient_to_nearest_pose
  import nonp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // coord_x, coord_y, coord_z, in_normal_x, in_normal_y, in_normal_z
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic [CMD_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_normal_x, out_normal_y, out_normal_z, flipped, nearest_index, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [STATUS_W-1:0]    out_tuser
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_RDBEST,
    S_DOT_WAIT,
    S_OUT
  } state_t;

  localparam int OFS_Y  = COORD_W;
  localparam int OFS_Z  = 2 * COORD_W;
  localparam int OFS_NX = 3 * COORD_W;
  localparam int OFS_NY = OFS_NX + NORMAL_W;
  localparam int OFS_NZ = OFS_NY + NORMAL_W;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] issue_r;
  logic [IDX_W-1:0] best_r;
  sum_t             best_d_r;
  pose_t            pt_r;
  norm_t            nx_r, ny_r, nz_r;
  norm_t            res_nx_r, res_ny_r, res_nz_r;
  logic             res_flip_r;
  logic [NEAR_W-1:0] res_idx_r;
  status_t          res_status_r;
  logic             out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  status_t          out_tuser_r;
  logic             mem_vld_r;
  dist_tag_t        mem_tag_r;

  logic             in_accept;
  cmd_t             in_cmd;
  pose_t            in_pose;
  norm_t            in_nx, in_ny, in_nz;
  logic             has_room;
  logic             wr_en;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  dist_tag_t        rd_tag;
  logic             scan_last;
  pose_t            rd_pose;
  logic             u_vld;
  dist_tag_t        u_tag;
  sum_t             u_sum;
  logic             do_flip;
  logic             out_load;

  function automatic norm_t neg_sat(input norm_t v);
    norm_t lo;
    lo = {1'b1, {(NORMAL_W-1){1'b0}}};
    if (v == lo) begin
      return ~lo;
    end
    return -v;
  endfunction

  assign in_cmd    = in_tuser;
  assign in_pose.x = in_tdata[OFS_Y-1:0];
  assign in_pose.y = in_tdata[OFS_Z-1:OFS_Y];
  assign in_pose.z = in_tdata[OFS_NX-1:OFS_Z];
  assign in_nx     = in_tdata[OFS_NY-1:OFS_NX];
  assign in_ny     = in_tdata[OFS_NZ-1:OFS_NY];
  assign in_nz     = in_tdata[OFS_NZ+NORMAL_W-1:OFS_NZ];

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign has_room  = (count_r < CNT_W'(MAX_POSES));
  assign wr_en     = in_accept && (in_cmd == CMD_APPEND) && has_room;

  assign scan_last = (CNT_W'(issue_r) == count_r - CNT_W'(1));
  assign rd_en     = (state_r == S_SCAN) || (state_r == S_RDBEST);
  assign rd_addr   = (state_r == S_RDBEST) ? best_r : issue_r;

  always_comb begin
    rd_tag.dot  = (state_r == S_RDBEST);
    rd_tag.last = (state_r == S_RDBEST) || scan_last;
    rd_tag.idx  = rd_addr;
  end

  // A pose on the point itself, or a zero normal, has no defined angle.
  assign do_flip = (best_d_r != '0) && ((nx_r | ny_r | nz_r) != '0) &&
                   (u_sum <= sum_t'(0));
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  nonp_pose_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (in_pose),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_pose)
  );

  nonp_dist_unit u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (mem_vld_r),
    .in_tag  (mem_tag_r),
    .pose    (rd_pose),
    .point   (pt_r),
    .nrm_x   (nx_r),
    .nrm_y   (ny_r),
    .nrm_z   (nz_r),
    .out_vld (u_vld),
    .out_tag (u_tag),
    .out_sum (u_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      mem_vld_r   <= 1'b0;
    end else begin
      mem_vld_r <= rd_en;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            case (in_cmd)
              CMD_APPEND: begin
                if (has_room) begin
                  count_r <= count_r + CNT_W'(1);
                end
                state_r <= S_OUT;
              end
              CMD_CLEAR: begin
                count_r <= '0;
                state_r <= S_OUT;
              end
              CMD_ORIENT: begin
                state_r <= (count_r == '0) ? S_OUT : S_SCAN;
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            state_r <= S_SCAN_WAIT;
          end
        end
        S_SCAN_WAIT: begin
          if (u_vld && u_tag.last) begin
            state_r <= S_RDBEST;
          end
        end
        S_RDBEST: begin
          state_r <= S_DOT_WAIT;
        end
        S_DOT_WAIT: begin
          if (u_vld && u_tag.dot) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end

    mem_tag_r <= rd_tag;

    if (state_r == S_SCAN) begin
      issue_r <= issue_r + IDX_W'(1);
    end else begin
      issue_r <= '0;
    end

    // Strictly smaller distance replaces the best, so the lowest index wins a tie.
    if (u_vld && !u_tag.dot && ((u_tag.idx == '0) || (u_sum < best_d_r))) begin
      best_d_r <= u_sum;
      best_r   <= u_tag.idx;
    end

    if (in_accept) begin
      pt_r       <= in_pose;
      nx_r       <= in_nx;
      ny_r       <= in_ny;
      nz_r       <= in_nz;
      res_nx_r   <= (in_cmd == CMD_ORIENT) ? in_nx : '0;
      res_ny_r   <= (in_cmd == CMD_ORIENT) ? in_ny : '0;
      res_nz_r   <= (in_cmd == CMD_ORIENT) ? in_nz : '0;
      res_flip_r <= 1'b0;
      res_idx_r  <= '0;
      case (in_cmd)
        CMD_APPEND: res_status_r <= has_room ? ST_STORED : ST_DROPPED;
        CMD_CLEAR:  res_status_r <= ST_CLEARED;
        CMD_ORIENT: res_status_r <= (count_r == '0) ? ST_NO_POSES : ST_ORIENTED;
        default:    res_status_r <= ST_DROPPED;
      endcase
    end else if ((state_r == S_DOT_WAIT) && u_vld && u_tag.dot) begin
      res_nx_r   <= do_flip ? neg_sat(nx_r) : nx_r;
      res_ny_r   <= do_flip ? neg_sat(ny_r) : ny_r;
      res_nz_r   <= do_flip ? neg_sat(nz_r) : nz_r;
      res_flip_r <= do_flip;
      res_idx_r  <= NEAR_W'(best_r);
    end

    if (out_load) begin
      out_tdata_r <= OUT_TDATA_W'({res_idx_r, res_flip_r, res_nz_r, res_ny_r, res_nx_r});
      out_tuser_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire
